// ===== rtl/hse_pkg.sv =====
// Types and constants shared by the hall speed estimator.
// No dependencies.
package hse_pkg;

    localparam int RPM_W  = 26;
    localparam int COEF_W = 16;
    localparam int PROD_W = RPM_W + COEF_W;
    localparam int DVD_W  = 33;
    localparam int DVS_W  = 24;

    localparam logic [RPM_W-1:0]  RPM_MAX  = {RPM_W{1'b1}};
    localparam logic [RPM_W-1:0]  HALF_RPM = 26'd128;
    localparam logic [RPM_W-1:0]  RPM_200  = 26'd51200;
    localparam logic [RPM_W-1:0]  RPM_800  = 26'd204800;
    localparam logic [DVD_W-1:0]  RPM_NUM2 = 33'd5120000000;

    localparam logic [COEF_W-1:0] K_ALPHA      = 16'd9830;
    localparam logic [COEF_W-1:0] K_DECAY_FILT = 16'd58982;
    localparam logic [COEF_W-1:0] K_DECAY_EST  = 16'd64225;
    localparam logic [COEF_W-1:0] K_OBS_LOW    = 16'd6554;
    localparam logic [COEF_W-1:0] K_OBS_MID    = 16'd16384;
    localparam logic [COEF_W-1:0] K_OBS_HIGH   = 16'd32768;

    localparam logic [1:0] REG_TIMEOUT    = 2'd0;
    localparam logic [1:0] REG_POLE_PAIRS = 2'd1;

    localparam logic [1:0] GAIN_LOW  = 2'd0;
    localparam logic [1:0] GAIN_MID  = 2'd1;
    localparam logic [1:0] GAIN_HIGH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_RPM_GO,
        ST_RPM,
        ST_FILT,
        ST_FMUL,
        ST_FADD,
        ST_OSET,
        ST_OMUL,
        ST_OADD,
        ST_OUT
    } t_state;

    function automatic logic [COEF_W-1:0] gain_of(input logic [1:0] sel);
        logic [COEF_W-1:0] g;
        case (sel)
            GAIN_LOW: g = K_OBS_LOW;
            GAIN_MID: g = K_OBS_MID;
            default:  g = K_OBS_HIGH;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/hse_if.sv =====
// Channel interfaces of the hall speed estimator: input, result and register write.
// No dependencies.
interface hse_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic        hall_u;
    logic        hall_v;
    logic        hall_w;
    logic [15:0] timer_count_us;
    logic [31:0] tick_ms;
    logic        direction_changed;
    modport source(output valid, operation, hall_u, hall_v, hall_w, timer_count_us,
                   tick_ms, direction_changed, input ready);
    modport sink(input valid, operation, hall_u, hall_v, hall_w, timer_count_us,
                 tick_ms, direction_changed, output ready);
endinterface

interface hse_out_if;
    logic        valid;
    logic        ready;
    logic        speed_ok;
    logic [25:0] rpm_observed;
    logic [25:0] rpm_filtered;
    logic [15:0] average_period_us;
    logic [15:0] hall_period_us;
    logic [7:0]  measure_count;
    logic        hall_accepted;
    modport source(output valid, speed_ok, rpm_observed, rpm_filtered,
                   average_period_us, hall_period_us, measure_count, hall_accepted,
                   input ready);
    modport sink(input valid, speed_ok, rpm_observed, rpm_filtered,
                 average_period_us, hall_period_us, measure_count, hall_accepted,
                 output ready);
endinterface

interface hse_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/hall_speed_estimator.sv =====
// Hall sample: result valid the cycle after acceptance. Speed tick: the bit-serial divider
// forms the window average, then rpm; the filter and observer multiplies run when needed.
// One transaction at a time; a new item is taken once the result has been taken.
// Synchronous active-low reset clears all but the tick flags and operands; timeout resets
// to 50 ms, pole pairs to 4. Depends on hse_pkg, hse_if and hse_div.
module hall_speed_estimator
    import hse_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8,
    parameter int TIMER_PERIOD = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hse_in_if.sink    i_in,
    hse_cfg_if.sink   i_cfg,
    hse_out_if.source o_out
);
    localparam int SUM_W = $clog2(WINDOW_DEPTH * 65535 + 1);
    localparam logic [16:0] TPER = 17'(TIMER_PERIOD);

    t_state            r_state, n_state;
    logic [15:0]       r_tmo, n_tmo;
    logic [6:0]        r_pp, n_pp;
    logic [2:0]        r_prev, n_prev;
    logic [15:0]       r_last_cnt, n_last_cnt;
    logic [15:0]       r_period, n_period;
    logic [31:0]       r_last_ms, n_last_ms;
    logic [15:0]       r_win [WINDOW_DEPTH];
    logic [15:0]       n_win [WINDOW_DEPTH];
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [15:0]       r_avg, n_avg;
    logic              r_valid, n_valid;
    logic [6:0]        r_idle, n_idle;
    logic [RPM_W-1:0]  r_filt, n_filt;
    logic [RPM_W-1:0]  r_est, n_est;
    logic [RPM_W-1:0]  r_obs, n_obs;
    logic [1:0]        r_gain, n_gain;
    logic [7:0]        r_vcnt, n_vcnt;
    logic              r_acc, n_acc;
    logic              r_gt, n_gt;
    logic              r_lt, n_lt;
    logic              r_dtnz, n_dtnz;
    logic              r_dir, n_dir;
    logic [RPM_W-1:0]  r_raw, n_raw;
    logic [RPM_W-1:0]  r_mul_a, n_mul_a;
    logic [COEF_W-1:0] r_mul_c, n_mul_c;
    logic              r_neg, n_neg;
    logic              r_decay, n_decay;
    logic [PROD_W-1:0] r_prod, n_prod;

    logic              div_start, div_done;
    logic [DVD_W-1:0]  div_dividend, div_q;
    logic [DVS_W-1:0]  div_divisor;

    logic [2:0]        code;
    logic [16:0]       span;
    logic [31:0]       since;
    logic [22:0]       denom;
    logic [RPM_W:0]    scaled;
    logic [RPM_W+1:0]  blend_sum;
    logic [RPM_W-1:0]  fin, base;
    logic [6:0]        idle0, idle1;
    logic              in_go;

    hse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign code  = {i_in.hall_u, i_in.hall_v, i_in.hall_w};
    assign in_go = i_in.valid && (r_state == ST_IDLE);
    assign since = i_in.tick_ms - r_last_ms;
    assign span  = (i_in.timer_count_us >= r_last_cnt)
                 ? 17'(i_in.timer_count_us - r_last_cnt)
                 : TPER - 17'(r_last_cnt) + 17'(i_in.timer_count_us);
    assign denom = 23'(r_avg) * 23'(r_pp);

    // finish a multiply: rounded scale, then move toward target or plain decay
    assign base      = (r_state == ST_FADD) ? r_filt : r_est;
    assign scaled    = (RPM_W + 1)'((r_prod + PROD_W'(32768)) >> COEF_W);
    assign blend_sum = r_neg ? (RPM_W + 2)'(base) - (RPM_W + 2)'(scaled)
                             : (RPM_W + 2)'(base) + (RPM_W + 2)'(scaled);
    always_comb begin
        if (r_decay) begin
            fin = (scaled < (RPM_W + 1)'(HALF_RPM)) ? '0 : scaled[RPM_W-1:0];
        end else if (blend_sum > (RPM_W + 2)'(RPM_MAX)) begin
            fin = RPM_MAX;
        end else begin
            fin = blend_sum[RPM_W-1:0];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_tmo      = r_tmo;
        n_pp       = r_pp;
        n_prev     = r_prev;
        n_last_cnt = r_last_cnt;
        n_period   = r_period;
        n_last_ms  = r_last_ms;
        n_win      = r_win;
        n_sum      = r_sum;
        n_avg      = r_avg;
        n_valid    = r_valid;
        n_idle     = r_idle;
        n_filt     = r_filt;
        n_est      = r_est;
        n_obs      = r_obs;
        n_gain     = r_gain;
        n_vcnt     = r_vcnt;
        n_acc      = r_acc;
        n_gt       = r_gt;
        n_lt       = r_lt;
        n_dtnz     = r_dtnz;
        n_dir      = r_dir;
        n_raw      = r_raw;
        n_mul_a    = r_mul_a;
        n_mul_c    = r_mul_c;
        n_neg      = r_neg;
        n_decay    = r_decay;
        n_prod     = PROD_W'(r_mul_a) * PROD_W'(r_mul_c);
        div_start    = 1'b0;
        div_dividend = DVD_W'(n_sum);
        div_divisor  = DVS_W'(WINDOW_DEPTH);
        idle0 = r_lt ? '0 : r_idle;
        idle1 = (idle0 < 7'd127) ? idle0 + 1'b1 : idle0;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TIMEOUT:    n_tmo = i_cfg.data;
                REG_POLE_PAIRS: n_pp  = i_cfg.data[6:0];
                default:        ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_go && !i_in.operation) begin
                    n_acc = 1'b0;
                    if (code != 3'd0 && code != 3'd7) begin
                        if (code != r_prev) begin
                            n_period   = span[15:0];
                            n_last_cnt = i_in.timer_count_us;
                            n_prev     = code;
                            n_acc      = 1'b1;
                        end
                        n_last_ms = i_in.tick_ms;
                    end
                    n_state = ST_OUT;
                end else if (in_go) begin
                    n_acc  = 1'b0;
                    n_gt   = since > 32'(r_tmo);
                    n_lt   = since < 32'(r_tmo);
                    n_dtnz = r_period != '0;
                    n_dir  = i_in.direction_changed;
                    if (r_period != '0) begin
                        // oldest period falls off the end of the line
                        n_sum = r_sum - SUM_W'(r_win[WINDOW_DEPTH-1]) + SUM_W'(r_period);
                        for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
                            n_win[i] = r_win[i-1];
                        end
                        n_win[0]     = r_period;
                        div_start    = 1'b1;
                        div_dividend = DVD_W'(n_sum);
                        n_state      = ST_AVG;
                    end else begin
                        n_state = ST_RPM_GO;
                    end
                end
            end
            ST_AVG: begin
                if (div_done) begin
                    n_avg   = div_q[15:0];
                    n_state = ST_RPM_GO;
                end
            end
            ST_RPM_GO: begin
                if (r_avg == '0) begin
                    n_raw   = '0;
                    n_state = ST_FILT;
                end else if (r_pp == '0) begin
                    n_raw   = RPM_MAX;
                    n_state = ST_FILT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = RPM_NUM2 + DVD_W'(denom);
                    div_divisor  = {denom, 1'b0};
                    n_state      = ST_RPM;
                end
            end
            ST_RPM: begin
                if (div_done) begin
                    n_raw   = (div_q > DVD_W'(RPM_MAX)) ? RPM_MAX : div_q[RPM_W-1:0];
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                n_state = ST_OSET;
                if (r_dir) begin
                    n_vcnt  = '0;
                    n_sum   = '0;
                    n_valid = 1'b0;
                    n_est   = '0;
                    for (int i = 0; i < WINDOW_DEPTH; i++) begin
                        n_win[i] = '0;
                    end
                end
                if (r_valid && !r_dir) begin
                    n_valid = !r_gt;
                    if (r_dtnz) begin
                        if (r_vcnt != 8'hFF) begin
                            n_vcnt = r_vcnt + 1'b1;
                        end
                        n_neg   = r_raw < r_filt;
                        n_mul_a = n_neg ? r_filt - r_raw : r_raw - r_filt;
                        n_mul_c = K_ALPHA;
                        n_decay = 1'b0;
                        n_state = ST_FMUL;
                    end else begin
                        n_vcnt = '0;
                    end
                end else begin
                    if (r_lt) begin
                        n_valid = 1'b1;
                    end
                    n_idle = idle1;
                    if (idle1 > 7'd100) begin
                        n_mul_a = r_filt;
                        n_mul_c = K_DECAY_FILT;
                        n_decay = 1'b1;
                        n_state = ST_FMUL;
                    end else if (r_filt < HALF_RPM) begin
                        n_filt = '0;
                    end
                end
            end
            ST_FMUL: n_state = ST_FADD;
            ST_FADD: begin
                n_filt  = fin;
                n_state = ST_OSET;
            end
            ST_OSET: begin
                if (r_dtnz && r_filt > HALF_RPM) begin
                    if (r_valid) begin
                        n_neg   = r_raw < r_est;
                        n_mul_a = n_neg ? r_est - r_raw : r_raw - r_est;
                        n_mul_c = gain_of(r_gain);
                        n_decay = 1'b0;
                    end else begin
                        n_mul_a = r_est;
                        n_mul_c = K_DECAY_EST;
                        n_decay = 1'b1;
                    end
                    n_state = ST_OMUL;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OMUL: n_state = ST_OADD;
            ST_OADD: begin
                n_est = fin;
                n_obs = fin;
                if (fin < RPM_200) begin
                    n_gain = GAIN_LOW;
                end else if (fin < RPM_800) begin
                    n_gain = GAIN_MID;
                end else begin
                    n_gain = GAIN_HIGH;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tmo      <= 16'd50;
            r_pp       <= 7'd4;
            r_prev     <= '0;
            r_last_cnt <= '0;
            r_period   <= '0;
            r_last_ms  <= '0;
            r_sum      <= '0;
            r_avg      <= '0;
            r_valid    <= 1'b0;
            r_idle     <= '0;
            r_filt     <= '0;
            r_est      <= '0;
            r_obs      <= '0;
            r_gain     <= GAIN_LOW;
            r_vcnt     <= '0;
            r_acc      <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_tmo      <= n_tmo;
            r_pp       <= n_pp;
            r_prev     <= n_prev;
            r_last_cnt <= n_last_cnt;
            r_period   <= n_period;
            r_last_ms  <= n_last_ms;
            r_sum      <= n_sum;
            r_avg      <= n_avg;
            r_valid    <= n_valid;
            r_idle     <= n_idle;
            r_filt     <= n_filt;
            r_est      <= n_est;
            r_obs      <= n_obs;
            r_gain     <= n_gain;
            r_vcnt     <= n_vcnt;
            r_acc      <= n_acc;
            r_win      <= n_win;
        end
        r_gt    <= n_gt;
        r_lt    <= n_lt;
        r_dtnz  <= n_dtnz;
        r_dir   <= n_dir;
        r_raw   <= n_raw;
        r_mul_a <= n_mul_a;
        r_mul_c <= n_mul_c;
        r_neg   <= n_neg;
        r_decay <= n_decay;
        r_prod  <= n_prod;
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid             = (r_state == ST_OUT);
    assign o_out.speed_ok          = r_valid;
    assign o_out.rpm_observed      = r_obs;
    assign o_out.rpm_filtered      = r_filt;
    assign o_out.average_period_us = r_avg;
    assign o_out.hall_period_us    = r_period;
    assign o_out.measure_count     = r_vcnt;
    assign o_out.hall_accepted     = r_acc;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("input taken while a result is pending");
    a_hall_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.operation) |=> o_out.valid)
        else $error("hall sample result late");
    a_tick_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.operation) |=> !r_acc)
        else $error("hall_accepted set on a speed tick");
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OADD) |=> (r_gain != 2'd3))
        else $error("gain select out of range after observer update");
`endif
endmodule

// ===== rtl/hse_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on hse_pkg.
module hse_div
    import hse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_q[DVD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W - 1);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // shift one dividend bit in, subtract when it fits
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DVS_W'(trial - {1'b0, r_dvs});
                n_q   = {r_q[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DVS_W-1:0];
                n_q   = {r_q[DVD_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule
